// ----- hw/rtl/lurt_pkg.sv -----
// Shared types and constants for the longest unique run tracker.
package lurt_pkg;

    localparam int unsigned SYM_W    = 8;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned ALPHABET = 256;
    localparam int unsigned ADDR_W   = $clog2(ALPHABET);

    // Longest string prefix that is counted; later bytes only raise the overflow flag.
    localparam logic [POS_W-1:0] MAX_LEN = 16'hFFFF;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             end_of_string;
    } t_req;

    typedef struct packed {
        logic [POS_W-1:0] longest_run;
        logic             overflow;
    } t_res;

endpackage

// ----- hw/rtl/longest_unique_run_tracker.sv -----
// Top level of the longest unique run tracker: table lookup, window update and result register.
//
// The block takes one byte per request and reports, on the byte flagged as the end of the
// string, the length of the longest run of bytes with no repeated value, plus a flag that
// says the string ran past 65535 bytes (only the first 65535 are counted). It sustains one
// byte per clock cycle while the input is not stalled. A request passes two stages: at
// acceptance the last position of its byte value is read from a 256-entry RAM, and when
// stage one retires it the window start, the best length and the table are updated; the
// result is then held in an output register, so o_out_valid rises after stage one retires
// the last byte, and the result can be taken at an edge where the output is not stalled.
// The RAM read is the only access with latency; when the previous byte has the same value,
// its position is forwarded instead of the stale RAM word. The table needs no clearing: a
// 256-bit valid vector in flip-flops marks the values seen in the current string, and it is
// cleared when a string ends. Input stall rises only while a finished result waits in the
// output register and the final byte of the next string stands behind it.
module longest_unique_run_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lurt_pkg::t_req     i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lurt_pkg::t_res     o_out_res
);

    // Stage one holds the request whose table word is being read.
    logic                           r_s1_valid;
    logic [lurt_pkg::ADDR_W-1:0]    r_s1_sym;
    logic                           r_s1_last;
    logic                           r_fwd_hit;
    logic [lurt_pkg::POS_W-1:0]     r_fwd_pos;

    // Per-string state.
    logic [lurt_pkg::ALPHABET-1:0]  r_seen;
    logic [lurt_pkg::POS_W-1:0]     r_ws;
    logic [lurt_pkg::POS_W-1:0]     r_pos;
    logic [lurt_pkg::POS_W-1:0]     r_best;
    logic                           r_ovf;

    logic                           r_out_valid;
    lurt_pkg::t_res                 r_out_res;

    logic                           n_s1_valid;
    logic [lurt_pkg::ALPHABET-1:0]  n_seen;
    logic [lurt_pkg::POS_W-1:0]     n_ws;
    logic [lurt_pkg::POS_W-1:0]     n_pos;
    logic [lurt_pkg::POS_W-1:0]     n_best;
    logic                           n_ovf;
    logic                           n_out_valid;

    logic                           in_accept;
    logic                           s1_go;
    logic                           s1_count;
    logic [lurt_pkg::ADDR_W-1:0]    in_sym;
    logic [lurt_pkg::POS_W-1:0]     ram_rdata;
    logic [lurt_pkg::POS_W-1:0]     last_pos;
    logic                           repeat_hit;
    logic [lurt_pkg::POS_W-1:0]     ws_upd;
    logic [lurt_pkg::POS_W-1:0]     run_len;
    logic [lurt_pkg::POS_W-1:0]     best_upd;

    // The symbol is reduced to the alphabet by keeping its low address bits.
    assign in_sym = i_in_req.symbol[lurt_pkg::ADDR_W-1:0];

    // Stage one retires unless it carries a result and the output register cannot take it.
    assign s1_go      = r_s1_valid && (!r_s1_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_accept  = i_in_valid && !o_in_stall;

    // A byte is counted only while the string is still within the maximum length.
    assign s1_count = (r_pos < lurt_pkg::MAX_LEN);

    lurt_ram #(
        .WIDTH (lurt_pkg::POS_W),
        .DEPTH (lurt_pkg::ALPHABET)
    ) u_last_seen (
        .i_clk   (i_clk),
        .i_we    (s1_go && s1_count),
        .i_waddr (r_s1_sym),
        .i_wdata (r_pos),
        .i_re    (in_accept),
        .i_raddr (in_sym),
        .o_rdata (ram_rdata)
    );

    // The previous byte writes the table at the same edge this one reads it, so its
    // position is forwarded when both carry the same value.
    assign last_pos   = r_fwd_hit ? r_fwd_pos : ram_rdata;
    assign repeat_hit = r_seen[r_s1_sym] && (last_pos >= r_ws);
    assign ws_upd     = repeat_hit ? last_pos + 1'b1 : r_ws;
    assign run_len    = r_pos - ws_upd + 1'b1;
    assign best_upd   = (run_len > r_best) ? run_len : r_best;

    always_comb begin
        n_seen = r_seen;
        n_ws   = r_ws;
        n_pos  = r_pos;
        n_best = r_best;
        n_ovf  = r_ovf;
        if (s1_go) begin
            if (r_s1_last) begin
                // The string ends here: its result is captured below and all state restarts.
                n_seen = '0;
                n_ws   = '0;
                n_pos  = '0;
                n_best = '0;
                n_ovf  = 1'b0;
            end else if (s1_count) begin
                n_seen[r_s1_sym] = 1'b1;
                n_ws             = ws_upd;
                n_pos            = r_pos + 1'b1;
                n_best           = best_upd;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_go && r_s1_last) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_seen      <= '0;
            r_ws        <= '0;
            r_pos       <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_seen      <= n_seen;
            r_ws        <= n_ws;
            r_pos       <= n_pos;
            r_best      <= n_best;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_sym  <= in_sym;
            r_s1_last <= i_in_req.end_of_string;
            r_fwd_hit <= r_s1_valid && s1_count && (r_s1_sym == in_sym);
            r_fwd_pos <= r_pos;
        end
        if (s1_go && r_s1_last) begin
            // The last byte itself counts toward the result when it is within the limit.
            r_out_res.longest_run <= s1_count ? best_upd : r_best;
            r_out_res.overflow    <= r_ovf || !s1_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule

// ----- hw/rtl/lurt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lurt_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/sv/lurt_tb_pkg.sv -----
// Scoreboard for the longest unique run tracker: run prediction and result comparison.
package lurt_tb_pkg;

    import lurt_pkg::*;

    class lurt_scoreboard;

        bit          value_seen[ALPHABET];
        int unsigned value_last_pos[ALPHABET];
        int unsigned win_start;
        int unsigned str_pos;
        int unsigned best_run;
        bit          ovf_seen;

        t_res        expected_runs[$];
        int unsigned errors;
        int unsigned results_checked;
        int unsigned strings_seen;
        int unsigned overflow_strings;

        function void note_request(t_req req);
            int unsigned sym;
            int unsigned run;
            t_res        want;
            sym = req.symbol;
            if (str_pos < int'(MAX_LEN)) begin
                if (value_seen[sym] && value_last_pos[sym] >= win_start) begin
                    win_start = value_last_pos[sym] + 1;
                end
                run = str_pos - win_start + 1;
                if (run > best_run) begin
                    best_run = run;
                end
                value_last_pos[sym] = str_pos;
                value_seen[sym] = 1'b1;
                str_pos++;
            end else begin
                ovf_seen = 1'b1;
            end
            if (req.end_of_string) begin
                want.longest_run = (best_run > 32'hFFFF) ? 16'hFFFF : 16'(best_run);
                want.overflow    = ovf_seen;
                expected_runs.insert(expected_runs.size(), want);
                strings_seen++;
                if (ovf_seen) begin
                    overflow_strings++;
                end
                value_seen = '{default: 1'b0};
                win_start = 0;
                str_pos = 0;
                best_run = 0;
                ovf_seen = 1'b0;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_runs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result longest_run=%0d overflow=%0b",
                         $time, got.longest_run, got.overflow);
                return;
            end
            want = expected_runs.pop_front();
            results_checked++;
            if (got.longest_run !== want.longest_run) begin
                errors++;
                $display("%0t: longest_run mismatch: expected %0d, got %0d",
                         $time, want.longest_run, got.longest_run);
            end
            if (got.overflow !== want.overflow) begin
                errors++;
                $display("%0t: overflow mismatch: expected %0b, got %0b",
                         $time, want.overflow, got.overflow);
            end
        endfunction

        function int unsigned pending();
            return expected_runs.size();
        endfunction

    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top-level testbench for the longest unique run tracker.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lurt_pkg::*;
    import lurt_tb_pkg::*;

    // A stretch this long with no request and no result accepted means the block hung.
    localparam int unsigned STUCK_LIMIT = 2000;
    // Length of the forced output hold-off used to back the block up.
    localparam int unsigned HOLD_CYCLES = 90;
    // Random bytes sent in each of the three idling phases.
    localparam int unsigned PHASE_BYTES = 500;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_req    = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_res out_res;

    lurt_scoreboard sb;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned bytes_sent    = 0;
    int unsigned hold_seq      = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned stuck_cycles  = 0;

    longest_unique_run_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res)
    );

    always #5 i_clk = ~i_clk;

    // Offers one byte and returns at the edge where the block takes it. The valid line
    // is left high on return, so that back-to-back requests see no gap unless the idle
    // roll at the start of the next call asks for one.
    task automatic send_byte(logic [SYM_W-1:0] sym, bit last);
        t_req req;
        req.symbol = sym;
        req.end_of_string = last;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= req;
        @(posedge i_clk);
        // The stall seen right after the edge is the value the block held before it.
        while (in_stall) begin
            @(posedge i_clk);
        end
        sb.note_request(req);
        bytes_sent++;
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_byte(txt[i], i == txt.len() - 1);
        end
    endtask

    // A string whose bytes count upward and wrap, so every value appears and the best
    // run is the full alphabet once the string is long enough.
    task automatic send_counting_string(int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(8'(i), i == len - 1);
        end
    endtask

    // Random strings draw from a window of byte values whose width sets how often values
    // repeat: narrow windows give many repeats and short runs, the full window few.
    task automatic send_random_string();
        int unsigned len;
        int unsigned span;
        int unsigned pick;
        logic [SYM_W-1:0] base;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            len = $urandom_range(1, 24);
        end else if (pick < 95) begin
            len = $urandom_range(25, 80);
        end else begin
            len = $urandom_range(81, 300);
        end
        case ($urandom_range(0, 5))
            0: span = 2;
            1: span = 4;
            2: span = 8;
            3: span = 16;
            4: span = 64;
            default: span = 256;
        endcase
        base = 8'($urandom);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(base + 8'($urandom_range(0, span - 1)), i == len - 1);
        end
    endtask

    task automatic send_random_bytes(int unsigned count);
        int unsigned target;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            send_random_string();
        end
    endtask

    // The sender pauses until every result it has caused has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // Receiver side: takes results, checks them, drives the output stall and watches
    // for a hang. A hold-off request from the sender starts a long stall counted here.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (out_valid && !out_stall) begin
                sb.check_result(out_res);
            end
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver heavily.
        set_idling(18, 55);

        // Single-byte strings at both ends of the byte range.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // A repeat inside the window moves its start; the best run here is three.
        send_text("abcabcbb");
        // The same byte back to back exercises the forwarding path.
        send_text("bbbb");
        // The second 'a' repeats a value that already lies before the window start.
        send_text("abba");
        // Extremes alternating, so each repeat hits right at the window edge.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_for_results();

        // Every byte value once in a single string, then random strings.
        send_counting_string(ALPHABET);
        send_random_bytes(PHASE_BYTES);
        wait_for_results();

        // Sender idles heavily, receiver lightly.
        set_idling(55, 18);
        send_random_bytes(PHASE_BYTES);
        wait_for_results();

        // No idling. First the receiver holds off for a long stretch while single-byte
        // strings keep coming, so results pile up and the block stalls its input.
        set_idling(0, 0);
        hold_seq <= hold_seq + 1;
        repeat (24) send_byte(8'($urandom), 1'b1);
        send_random_bytes(PHASE_BYTES);

        wait_for_results();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes in %0d strings, %0d of them past the length limit.",
                 bytes_sent, sb.strings_seen, sb.overflow_strings);
        $display("Compared %0d results; %0d mismatches.", sb.results_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
